>>> src/cbpl_pkg.sv
// Shared types, constants and codes for the cell bitmap pixel and line engine.
`timescale 1ns / 1ps

package cbpl_pkg;

  // Bitmap geometry, in 8x8 character cells
  localparam int CELL_COLUMNS = 40;
  localparam int CELL_ROWS    = 25;
  localparam int STORE_DEPTH  = 8192;

  localparam int PIX_WIDTH  = CELL_COLUMNS * 8;
  localparam int PIX_HEIGHT = CELL_ROWS * 8;

  // Widths
  localparam int STORE_AW = $clog2(STORE_DEPTH);
  localparam int COORD_W  = 10;  // walking coordinate, room to step past the edge
  localparam int LEN_W    = 9;
  localparam int CALC_W   = 18;  // unclipped byte address
  localparam int CNT_W    = 4;   // pixels covered by one byte step, 1..8

  // Command codes
  localparam logic [2:0] OP_PIXEL = 3'd0;
  localparam logic [2:0] OP_HRUN  = 3'd1;
  localparam logic [2:0] OP_VRUN  = 3'd2;
  localparam logic [2:0] OP_FILL  = 3'd3;
  localparam logic [2:0] OP_READ  = 3'd4;

  // Result status codes
  localparam logic ST_DONE    = 1'b0;
  localparam logic ST_CLIPPED = 1'b1;

  typedef struct packed {
    logic [2:0] opcode;
    logic       set_pixels;
    logic [8:0] x_coord;
    logic [7:0] y_coord;
    logic [8:0] run_length;
    logic [7:0] fill_value;
  } in_item_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic       status;
  } out_item_t;

  // Sequencer states
  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_STEP,
    S_MODIFY,
    S_READ_WAIT,
    S_FILL,
    S_RESP
  } state_t;

  // Walking position handed to the address unit
  typedef struct packed {
    logic [COORD_W-1:0] cur_x;
    logic [COORD_W-1:0] cur_y;
    logic [LEN_W-1:0]   rem;
    logic               vertical;
  } walk_t;

  // Byte location and mask returned by the address unit
  typedef struct packed {
    logic [STORE_AW-1:0] addr;
    logic                beyond;
    logic [7:0]          mask;
    logic [CNT_W-1:0]    count;
  } loc_t;

  // Store port request
  typedef struct packed {
    logic                we;
    logic [STORE_AW-1:0] waddr;
    logic [7:0]          wdata;
    logic                re;
    logic [STORE_AW-1:0] raddr;
  } mem_req_t;

  // Finished result offered to the output register
  typedef struct packed {
    logic      valid;
    out_item_t item;
  } res_t;

endpackage

>>> src/cbpl_addr_unit.sv
// Shared address and mask unit: byte address, pixel mask and step size of one byte step.
`timescale 1ns / 1ps

module cbpl_addr_unit
  import cbpl_pkg::*;
(
  input  walk_t walk,
  output loc_t  loc
);

  logic [CALC_W-1:0] full_addr;
  logic [2:0]        bit_ofs;
  logic [CNT_W-1:0]  room;
  logic [CNT_W-1:0]  count;
  logic [CNT_W-1:0]  stop;

  // Cell-order address: row of cells, byte column, line inside the cell
  assign full_addr = CALC_W'(PIX_WIDTH) * CALC_W'(walk.cur_y[COORD_W-1:3])
                   + CALC_W'({walk.cur_x[COORD_W-1:3], 3'b000})
                   + CALC_W'(walk.cur_y[2:0]);

  // Pixels left in this byte, limited by the remaining run
  assign bit_ofs = walk.cur_x[2:0];
  assign room    = CNT_W'(8) - CNT_W'(bit_ofs);

  always_comb begin
    if (walk.vertical) begin
      count = CNT_W'(1);
    end else if (LEN_W'(room) < walk.rem) begin
      count = room;
    end else begin
      count = walk.rem[CNT_W-1:0];
    end
  end

  assign stop = CNT_W'(bit_ofs) + count;

  always_comb begin
    loc.addr   = full_addr[STORE_AW-1:0];
    loc.beyond = (full_addr >= CALC_W'(STORE_DEPTH));
    loc.count  = count;
    if (walk.vertical) begin
      loc.mask = 8'h80 >> bit_ofs;
    end else begin
      loc.mask = (8'hff >> bit_ofs) & ~(8'hff >> stop);
    end
  end

endmodule

>>> src/cbpl_store.sv
// Bitmap byte store: one write port, one read port with registered data.
`timescale 1ns / 1ps

module cbpl_store
  import cbpl_pkg::*;
(
  input  logic       clk,
  input  mem_req_t   req,
  output logic [7:0] rd_data_r
);

  logic [7:0] mem [STORE_DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
  end

  // Read port
  always_ff @(posedge clk) begin
    if (req.re) begin
      rd_data_r <= mem[req.raddr];
    end
  end

endmodule

>>> src/cbpl_ctrl.sv
// Command sequencer: decodes an item, walks runs byte by byte, sweeps the store.
`timescale 1ns / 1ps

module cbpl_ctrl
  import cbpl_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  in_item_t   in_item,
  output logic       idle,
  output walk_t      walk,
  input  loc_t       loc,
  output mem_req_t   mem_req,
  input  logic [7:0] rd_data,
  output res_t       res,
  input  logic       res_ready
);

  state_t state_r, state_nxt;

  logic [2:0]          op_r, op_nxt;
  logic                ink_r, ink_nxt;
  logic [COORD_W-1:0]  cur_x_r, cur_x_nxt;
  logic [COORD_W-1:0]  cur_y_r, cur_y_nxt;
  logic [LEN_W-1:0]    rem_r, rem_nxt;
  logic [7:0]          fill_r, fill_nxt;
  logic [STORE_AW-1:0] sweep_r, sweep_nxt;
  logic [STORE_AW-1:0] addr_r, addr_nxt;
  logic [7:0]          mask_r, mask_nxt;
  logic [CNT_W-1:0]    step_n_r, step_n_nxt;
  logic [7:0]          data_r, data_nxt;
  logic                status_r, status_nxt;

  logic on_map;
  logic vertical;
  logic at_edge;
  logic sweep_last;

  assign on_map = ({1'b0, in_item.x_coord} < COORD_W'(PIX_WIDTH))
               && (COORD_W'(in_item.y_coord) < COORD_W'(PIX_HEIGHT));
  assign vertical = (op_r == OP_VRUN);
  assign at_edge  = vertical ? (cur_y_r >= COORD_W'(PIX_HEIGHT))
                             : (cur_x_r >= COORD_W'(PIX_WIDTH));
  assign sweep_last = (sweep_r == STORE_AW'(STORE_DEPTH - 1));

  assign idle = (state_r == S_IDLE);

  // Current walking position to the address unit
  assign walk.cur_x    = cur_x_r;
  assign walk.cur_y    = cur_y_r;
  assign walk.rem      = rem_r;
  assign walk.vertical = vertical;

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      sweep_r <= '0;
    end else begin
      state_r <= state_nxt;
      sweep_r <= sweep_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    op_r     <= op_nxt;
    ink_r    <= ink_nxt;
    cur_x_r  <= cur_x_nxt;
    cur_y_r  <= cur_y_nxt;
    rem_r    <= rem_nxt;
    fill_r   <= fill_nxt;
    addr_r   <= addr_nxt;
    mask_r   <= mask_nxt;
    step_n_r <= step_n_nxt;
    data_r   <= data_nxt;
    status_r <= status_nxt;
  end

  // Next state and outputs
  always_comb begin
    state_nxt  = state_r;
    op_nxt     = op_r;
    ink_nxt    = ink_r;
    cur_x_nxt  = cur_x_r;
    cur_y_nxt  = cur_y_r;
    rem_nxt    = rem_r;
    fill_nxt   = fill_r;
    sweep_nxt  = sweep_r;
    addr_nxt   = addr_r;
    mask_nxt   = mask_r;
    step_n_nxt = step_n_r;
    data_nxt   = data_r;
    status_nxt = status_r;
    mem_req    = '0;
    res.valid  = 1'b0;
    res.item.read_data = data_r;
    res.item.status    = status_r;

    case (state_r)
      // Zero sweep after reset
      S_CLEAR: begin
        mem_req.we    = 1'b1;
        mem_req.waddr = sweep_r;
        mem_req.wdata = 8'h00;
        sweep_nxt     = sweep_r + STORE_AW'(1);
        if (sweep_last) begin
          sweep_nxt = '0;
          state_nxt = S_IDLE;
        end
      end

      // Take and decode a command
      S_IDLE: begin
        if (in_valid) begin
          op_nxt     = in_item.opcode;
          ink_nxt    = in_item.set_pixels;
          cur_x_nxt  = COORD_W'(in_item.x_coord);
          cur_y_nxt  = COORD_W'(in_item.y_coord);
          fill_nxt   = in_item.fill_value;
          data_nxt   = 8'h00;
          status_nxt = ST_DONE;
          if (in_item.opcode == OP_PIXEL || in_item.opcode == OP_READ) begin
            rem_nxt = LEN_W'(1);
          end else begin
            rem_nxt = in_item.run_length;
          end
          if (in_item.opcode == OP_FILL) begin
            sweep_nxt = '0;
            state_nxt = S_FILL;
          end else if (!(in_item.opcode inside {OP_PIXEL, OP_HRUN, OP_VRUN, OP_READ})) begin
            state_nxt = S_RESP;
          end else if (!on_map) begin
            status_nxt = ST_CLIPPED;
            state_nxt  = S_RESP;
          end else begin
            state_nxt = S_STEP;
          end
        end
      end

      // One byte step: check the edge and the store, then read the byte
      S_STEP: begin
        if (rem_r == '0) begin
          state_nxt = S_RESP;
        end else if (at_edge || loc.beyond) begin
          status_nxt = ST_CLIPPED;
          state_nxt  = S_RESP;
        end else begin
          mem_req.re    = 1'b1;
          mem_req.raddr = loc.addr;
          addr_nxt      = loc.addr;
          mask_nxt      = loc.mask;
          step_n_nxt    = loc.count;
          state_nxt     = (op_r == OP_READ) ? S_READ_WAIT : S_MODIFY;
        end
      end

      // Merge the mask into the byte and advance
      S_MODIFY: begin
        mem_req.we    = 1'b1;
        mem_req.waddr = addr_r;
        mem_req.wdata = ink_r ? (rd_data | mask_r) : (rd_data & ~mask_r);
        rem_nxt       = rem_r - LEN_W'(step_n_r);
        if (vertical) begin
          cur_y_nxt = cur_y_r + COORD_W'(1);
        end else begin
          cur_x_nxt = cur_x_r + COORD_W'(step_n_r);
        end
        state_nxt = S_STEP;
      end

      S_READ_WAIT: begin
        data_nxt  = rd_data;
        state_nxt = S_RESP;
      end

      // Fill sweep, one byte a cycle
      S_FILL: begin
        mem_req.we    = 1'b1;
        mem_req.waddr = sweep_r;
        mem_req.wdata = fill_r;
        sweep_nxt     = sweep_r + STORE_AW'(1);
        if (sweep_last) begin
          sweep_nxt = '0;
          state_nxt = S_RESP;
        end
      end

      S_RESP: begin
        res.valid = 1'b1;
        if (res_ready) begin
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // A store write only comes from a sweep or the modify step
  a_write_source: assert property (@(posedge clk) disable iff (!rst_n)
    mem_req.we |-> (state_r == S_CLEAR || state_r == S_FILL || state_r == S_MODIFY))
    else $error("store write outside sweep or modify");

  // A byte step never covers more pixels than the run has left
  a_step_fits: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_MODIFY |-> (step_n_r != '0 && LEN_W'(step_n_r) <= rem_r))
    else $error("byte step exceeds remaining run");

  // Modify and read wait always follow a step that issued the read
  a_read_before_use: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_MODIFY || state_r == S_READ_WAIT) |-> $past(state_r) == S_STEP)
    else $error("store data used without a read");

  // A taken result frees the sequencer for the next item
  a_resp_release: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_RESP && res_ready) |=> state_r == S_IDLE)
    else $error("sequencer stuck after result taken");

endmodule

>>> src/cell_bitmap_pixel_line_engine_unit.sv
// Top level of the cell bitmap pixel and line engine: sequencer, address unit, store, output register.
// Accept to out_valid: S_IDLE decodes the item; a pixel or run steps through S_STEP and S_MODIFY
// once per byte step (horizontal) or pixel row (vertical), a read through S_STEP and S_READ_WAIT;
// a fill sweeps every byte in S_FILL; an off-map start or spare opcode goes straight to S_RESP.
// Items are taken one at a time; each byte step reads the byte in S_STEP and writes it in S_MODIFY
// through the store's read and write ports; results leave via S_RESP and the output register.
// Reset: a zero sweep of all STORE_DEPTH bytes clears the store; in_stall is high meanwhile.
`timescale 1ns / 1ps

module cell_bitmap_pixel_line_engine_unit
  import cbpl_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_item,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_item
);

  walk_t      walk;
  loc_t       loc;
  mem_req_t   mem_req;
  logic [7:0] rd_data;
  res_t       res;
  logic       res_ready;
  logic       idle;

  logic      out_valid_r;
  out_item_t out_item_r;

  cbpl_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_item   (in_item),
    .idle      (idle),
    .walk      (walk),
    .loc       (loc),
    .mem_req   (mem_req),
    .rd_data   (rd_data),
    .res       (res),
    .res_ready (res_ready)
  );

  cbpl_addr_unit u_addr (
    .walk (walk),
    .loc  (loc)
  );

  cbpl_store u_store (
    .clk       (clk),
    .req       (mem_req),
    .rd_data_r (rd_data)
  );

  assign in_stall = !idle;

  // Output register: frees the sequencer while a result waits
  assign res_ready = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res.valid && res_ready) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res.valid && res_ready) begin
      out_item_r <= res.item;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule
